>>> rtl/zapm_pkg.sv
// shared constants, opcodes and store control type for the prefix matcher
`default_nettype none
package zapm_pkg;

	localparam int MAX_PAT = 32;
	localparam int ADDR_W  = $clog2(MAX_PAT);
	localparam int CNT_W   = $clog2(MAX_PAT + 1);
	localparam int SYM_W   = 8;
	localparam int OP_W    = 2;
	localparam int POS_W   = 32;
	localparam int LEN_W   = 6;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_PAT   = 2'd1;
	localparam logic [OP_W-1:0] OP_TEXT  = 2'd2;

	// write and read controls toward the symbol stores
	typedef struct packed {
		logic              pat_we;
		logic [ADDR_W-1:0] pat_addr;
		logic              win_we;
		logic [ADDR_W-1:0] win_addr;
		logic [SYM_W-1:0]  wdata;
		logic [ADDR_W-1:0] pat_rd_addr;
		logic [ADDR_W-1:0] win_rd_addr;
	} store_ctl_t;

endpackage
`default_nettype wire

>>> rtl/zapm_if.sv
// valid/ready channel interfaces for input words and result words
`default_nettype none
interface zapm_in_if;
	import zapm_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [SYM_W-1:0] symbol;
	logic             last_text;

	modport source (output valid, output opcode, output symbol, output last_text,
		input ready);
	modport sink (input valid, input opcode, input symbol, input last_text,
		output ready);
endinterface

interface zapm_out_if;
	import zapm_pkg::*;

	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] match_length;
	logic [POS_W-1:0] text_position;
	logic             last_result;

	modport source (output valid, output match_length, output text_position,
		output last_result, input ready);
	modport sink (input valid, input match_length, input text_position,
		input last_result, output ready);
endinterface
`default_nettype wire

>>> rtl/zapm_store.sv
// pattern and text window memories with registered reads and the shared symbol compare
`default_nettype none
module zapm_store (
	input  logic                  clk,
	input  zapm_pkg::store_ctl_t  ctl,
	output logic                  eq
);
	import zapm_pkg::*;

	logic [SYM_W-1:0] pat_mem [MAX_PAT];
	logic [SYM_W-1:0] win_mem [MAX_PAT];
	logic [SYM_W-1:0] pat_rd_q;
	logic [SYM_W-1:0] win_rd_q;

	// one write and one registered read per memory each cycle
	always_ff @(posedge clk) begin
		if (ctl.pat_we) begin
			pat_mem[ctl.pat_addr] <= ctl.wdata;
		end
		if (ctl.win_we) begin
			win_mem[ctl.win_addr] <= ctl.wdata;
		end
		pat_rd_q <= pat_mem[ctl.pat_rd_addr];
		win_rd_q <= win_mem[ctl.win_rd_addr];
	end

	// shared compare unit
	assign eq = (pat_rd_q == win_rd_q);

endmodule
`default_nettype wire

>>> rtl/z_array_prefix_match.sv
// top level of the streaming prefix matcher: sequencer, counters and result register
//
// channel | dir | word fields                                | accepted when
// item    | in  | opcode, symbol, last_text                  | valid && ready
// result  | out | match_length, text_position, last_result   | valid && ready
//
// clear and pattern words, and a text word that reports nothing, finish in their accept cycle.
// each reported position goes through a setup state, passes of the single symbol compare
// over the two store read ports until a mismatch or the end of the shorter of pattern and
// window, and a step to load the result register. a flush reports every open position in turn.
// reset clears counters and control; the symbol memories are not cleared.
// a result waiting in the output register stalls only the next report, which keeps ready low.
`default_nettype none
module z_array_prefix_match (
	input  logic       clk,
	input  logic       arst_n,
	zapm_in_if.sink    item,
	zapm_out_if.source result
);
	import zapm_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_CMP   = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  plen_q;
	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] head_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  limit_q;
	logic [CNT_W-1:0]  z_q;

	logic              rv_q;
	logic [LEN_W-1:0]  rlen_q;
	logic [POS_W-1:0]  rpos_q;
	logic              rlast_q;

	logic              accept;
	logic              out_free;
	logic              win_room;
	logic [CNT_W-1:0]  fill_inc;
	logic              emit_now;
	logic [CNT_W-1:0]  rd_k;
	logic              eq;
	store_ctl_t        ctl;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !rv_q || result.ready;

	// window insert and report decision for a text word
	assign win_room = (fill_q < CNT_W'(MAX_PAT));
	assign fill_inc = win_room ? fill_q + CNT_W'(1) : fill_q;
	assign emit_now = (fill_inc >= plen_q) || item.last_text;

	// read index runs one ahead of the compare index
	assign rd_k = (state_q == S_CMP) ? k_q + CNT_W'(1) : '0;

	// store controls
	always_comb begin
		ctl.wdata       = item.symbol;
		ctl.pat_we      = accept && (item.opcode == OP_PAT) && (plen_q < CNT_W'(MAX_PAT));
		ctl.pat_addr    = plen_q[ADDR_W-1:0];
		ctl.win_we      = accept && (item.opcode == OP_TEXT) && win_room;
		ctl.win_addr    = head_q + fill_q[ADDR_W-1:0];
		ctl.pat_rd_addr = rd_k[ADDR_W-1:0];
		ctl.win_rd_addr = head_q + rd_k[ADDR_W-1:0];
	end

	zapm_store u_store (
		.clk (clk),
		.ctl (ctl),
		.eq  (eq)
	);

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			plen_q  <= '0;
			fill_q  <= '0;
			head_q  <= '0;
			pos_q   <= '0;
			last_q  <= 1'b0;
			k_q     <= '0;
			limit_q <= '0;
			z_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.opcode)
							OP_CLEAR: begin
								plen_q <= '0;
								fill_q <= '0;
								head_q <= '0;
								pos_q  <= '0;
							end
							OP_PAT: begin
								if (plen_q < CNT_W'(MAX_PAT)) begin
									plen_q <= plen_q + CNT_W'(1);
								end
							end
							OP_TEXT: begin
								fill_q <= fill_inc;
								pos_q  <= pos_q + POS_W'(1);
								last_q <= item.last_text;
								if (emit_now) begin
									state_q <= S_START;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_START: begin
					limit_q <= (plen_q < fill_q) ? plen_q : fill_q;
					k_q     <= '0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ((k_q < limit_q) && eq) begin
						k_q <= k_q + CNT_W'(1);
					end else begin
						z_q     <= k_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						fill_q <= fill_q - CNT_W'(1);
						head_q <= head_q + ADDR_W'(1);
						if (last_q && (fill_q > CNT_W'(1))) begin
							state_q <= S_START;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			rv_q <= 1'b1;
		end else if (result.ready) begin
			rv_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			rlen_q  <= LEN_W'(z_q);
			rpos_q  <= pos_q - POS_W'(fill_q);
			rlast_q <= last_q && (fill_q == CNT_W'(1));
		end
	end

	assign result.valid         = rv_q;
	assign result.match_length  = rlen_q;
	assign result.text_position = rpos_q;
	assign result.last_result   = rlast_q;

endmodule
`default_nettype wire

>>> rtl/zapm_checker.sv
// port level checks on the prefix matcher, bound to the top level
`default_nettype none
module zapm_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [zapm_pkg::OP_W-1:0]  in_opcode,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [zapm_pkg::LEN_W-1:0] out_match_length,
	input logic [zapm_pkg::POS_W-1:0] out_text_position,
	input logic                   out_last_result
);
	import zapm_pkg::*;

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// a stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_match_length) &&
		$stable(out_text_position) && $stable(out_last_result))
		else $error("result payload changed while stalled");

	// any word other than a text word finishes in its accept cycle and keeps ready up
	a_ctl_stays_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode != OP_TEXT) |=> in_ready)
		else $error("control word left the block busy");

	// match length never exceeds the pattern capacity
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_match_length <= LEN_W'(MAX_PAT))
		else $error("match length beyond pattern capacity");

endmodule

bind z_array_prefix_match zapm_checker u_zapm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (item.valid),
	.in_ready          (item.ready),
	.in_opcode         (item.opcode),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.out_match_length  (result.match_length),
	.out_text_position (result.text_position),
	.out_last_result   (result.last_result)
);
`default_nettype wire

>>> tb/tb_z_array_prefix_match.sv
// self-checking testbench for the streaming prefix matcher
module tb_z_array_prefix_match;
	timeunit 1ns;
	timeprecision 1ps;

	import zapm_pkg::*;

	localparam logic [OP_W-1:0]  OP_NONE      = 2'd3;
	localparam logic [SYM_W-1:0] SEP          = 8'h24;
	localparam int               RANDOM_WORDS = 305;
	localparam int               STALL_LIMIT  = 4000;
	localparam int               DRAIN_CYCLES = 200;
	localparam int               PLAN_ROWS    = 22;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [POS_W-1:0] pos;
		logic             last;
	} match_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SYM_W-1:0] sym;
		logic             last;
		logic             typed;
		logic             typed_one;
		match_t           want;
	} step_row_t;

	localparam match_t NO_MATCH = '0;

	logic clk;
	logic arst_n;

	zapm_in_if  in_ch ();
	zapm_out_if out_ch ();

	z_array_prefix_match uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch)
	);

	// matcher state as seen by the checker
	logic [SYM_W-1:0] pat_sym [MAX_PAT];
	logic [SYM_W-1:0] win_sym [MAX_PAT];
	int               pat_len;
	int               win_fill;
	logic [POS_W-1:0] pos_next;

	match_t pending_matches [$];

	int  errors;
	int  words_in;
	int  results_seen;
	int  longest;
	int  flush_runs;
	int  idle_cycles;
	bit  steady;

	// directed words: typed rows carry their expected result, the rest go through the checker model
	step_row_t plan [PLAN_ROWS] = '{
		'{OP_TEXT,  8'h00, 1'b0, 1'b1, 1'b1, '{6'd0, 32'd0, 1'b0}},
		'{OP_TEXT,  8'hff, 1'b1, 1'b1, 1'b1, '{6'd0, 32'd1, 1'b1}},
		'{OP_NONE,  8'haa, 1'b1, 1'b1, 1'b0, NO_MATCH},
		'{OP_CLEAR, 8'h55, 1'b1, 1'b1, 1'b0, NO_MATCH},
		'{OP_PAT,   8'h61, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_PAT,   8'h62, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_PAT,   8'h61, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  8'h61, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  8'h62, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  8'h61, 1'b0, 1'b1, 1'b1, '{6'd3, 32'd0, 1'b0}},
		'{OP_TEXT,  SEP,   1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  8'h61, 1'b1, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  8'h61, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_PAT,   8'h62, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  8'h62, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  8'h61, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  8'h62, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  8'h00, 1'b1, 1'b0, 1'b0, NO_MATCH},
		'{OP_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_PAT,   SEP,   1'b0, 1'b0, 1'b0, NO_MATCH},
		'{OP_TEXT,  SEP,   1'b1, 1'b1, 1'b1, '{6'd1, 32'd0, 1'b1}},
		'{OP_TEXT,  8'hff, 1'b1, 1'b1, 1'b1, '{6'd0, 32'd1, 1'b1}}
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// pattern prefix length matching the window from its oldest slot
	function automatic int oldest_prefix();
		int k;
		k = 0;
		while (k < pat_len && k < win_fill && win_sym[k] == pat_sym[k])
			k++;
		return k;
	endfunction

	// report the oldest open position and drop it from the window
	task automatic retire_oldest(input logic last, input bit keep);
		match_t m;
		m.len  = LEN_W'(oldest_prefix());
		m.pos  = pos_next - POS_W'(win_fill);
		m.last = last;
		if (keep)
			pending_matches = {pending_matches, m};
		for (int k = 0; k < win_fill - 1; k++)
			win_sym[k] = win_sym[k + 1];
		win_fill--;
	endtask

	// advance the matcher state by one word and queue the reports it causes
	task automatic predict_matches(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
		input logic last, input bit keep);
		int n;
		n = 0;
		case (op)
			OP_CLEAR: begin
				pat_len  = 0;
				win_fill = 0;
				pos_next = '0;
			end
			OP_PAT: begin
				if (pat_len < MAX_PAT) begin
					pat_sym[pat_len] = sym;
					pat_len++;
				end
			end
			OP_TEXT: begin
				if (win_fill < MAX_PAT) begin
					win_sym[win_fill] = sym;
					win_fill++;
				end
				pos_next++;
				if (win_fill > 0 && win_fill >= pat_len) begin
					retire_oldest(last && win_fill == 1, keep);
					n++;
				end
				// final text symbol flushes every open position
				if (last) begin
					while (win_fill > 0 && n < MAX_PAT) begin
						retire_oldest(win_fill == 1, keep);
						n++;
					end
					win_fill = 0;
				end
			end
			default: ;
		endcase
	endtask

	// drive one word, with random idle cycles ahead of it outside steady phases
	task automatic send_word(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
		input logic last, input bit typed = 1'b0, input bit typed_one = 1'b0,
		input match_t want = '0);
		while (!steady && $urandom_range(99) < 30) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.opcode    <= op;
		in_ch.symbol    <= sym;
		in_ch.last_text <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_matches(op, sym, last, !typed);
		if (typed && typed_one)
			pending_matches = {pending_matches, want};
		if (op != OP_NONE)
			words_in++;
	endtask

	function automatic logic [SYM_W-1:0] alpha_sym(input bit wide, input logic [SYM_W-1:0] a0,
		input logic [SYM_W-1:0] a1);
		if (wide)
			return SYM_W'($urandom_range(255));
		return $urandom_range(1) ? a1 : a0;
	endfunction

	// result checking, output stalls and watchdog
	always @(posedge clk) begin
		match_t got;
		match_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.match_length, out_ch.text_position, out_ch.last_result};
				if (pending_matches.size() == 0) begin
					flag_mismatch($sformatf("result word with none pending, position %0d",
						got.pos));
				end else begin
					want = pending_matches.pop_front();
					if (got.len !== want.len)
						flag_mismatch($sformatf("match_length %0d, want %0d at position %0d",
							got.len, want.len, want.pos));
					if (got.pos !== want.pos)
						flag_mismatch($sformatf("text_position %0d, want %0d",
							got.pos, want.pos));
					if (got.last !== want.last)
						flag_mismatch($sformatf("last_result %b, want %b at position %0d",
							got.last, want.last, want.pos));
				end
				results_seen++;
				if (int'(got.len) > longest)
					longest = int'(got.len);
				if (got.last === 1'b1)
					flush_runs++;
			end
			out_ch.ready <= steady || ($urandom_range(99) >= 30);

			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no word moved for %0d cycles, %0d results pending",
					idle_cycles, pending_matches.size());
				$display("tb_z_array_prefix_match: errors");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int               base;
		int               phase;
		int               plen;
		int               tl;
		int               cp;
		int               r;
		bit               full;
		bit               wide;
		logic [SYM_W-1:0] a0;
		logic [SYM_W-1:0] a1;
		logic [SYM_W-1:0] sym;

		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.opcode    = OP_CLEAR;
		in_ch.symbol    = '0;
		in_ch.last_text = 1'b0;
		out_ch.ready    = 1'b0;
		steady          = 1'b0;
		errors          = 0;
		words_in        = 0;
		results_seen    = 0;
		longest         = 0;
		flush_runs      = 0;
		idle_cycles     = 0;
		pat_len         = 0;
		win_fill        = 0;
		pos_next        = '0;
		phase           = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < PLAN_ROWS; i++)
			send_word(plan[i].op, plan[i].sym, plan[i].last, plan[i].typed,
				plan[i].typed_one, plan[i].want);

		// random phases: mostly pattern load plus text run, some noise
		base = words_in;
		while (words_in - base < RANDOM_WORDS) begin
			phase++;
			full   = (phase == 1);
			steady = (phase >= 6 && phase < 10);

			// hold off until every pending report is out
			if (phase == 4 || $urandom_range(7) == 0) begin
				if (pending_matches.size() != 0) begin
					in_ch.valid <= 1'b0;
					while (pending_matches.size() != 0)
						@(posedge clk);
				end
			end

			if (!full && $urandom_range(99) < 10) begin
				repeat ($urandom_range(1, 6))
					send_word(OP_W'($urandom_range(3)), SYM_W'($urandom_range(255)),
						1'($urandom_range(1)));
			end else begin
				wide = ($urandom_range(4) == 0);
				a0   = SYM_W'($urandom_range(255));
				a1   = a0 ^ SYM_W'(1 << $urandom_range(SYM_W - 1));
				if (full || $urandom_range(9) != 0)
					send_word(OP_CLEAR, SYM_W'($urandom_range(255)), 1'($urandom_range(1)));

				r = $urandom_range(99);
				if (full)
					plen = MAX_PAT + 2;
				else if (r < 5)
					plen = 0;
				else if (r < 12)
					plen = $urandom_range(28, MAX_PAT + 2);
				else
					plen = $urandom_range(1, 6);
				repeat (plen)
					send_word(OP_PAT, alpha_sym(wide, a0, a1), 1'($urandom_range(1)));

				tl = full ? MAX_PAT : $urandom_range(1, 10) + (plen > 20 ? plen : 0);
				cp = 0;
				for (int i = 0; i < tl; i++) begin
					// pattern growth and dead opcodes in the middle of a run
					if (!full && $urandom_range(99) < 3)
						send_word(OP_PAT, alpha_sym(wide, a0, a1), 1'($urandom_range(1)));
					if (!full && $urandom_range(99) < 3)
						send_word(OP_NONE, SYM_W'($urandom_range(255)), 1'($urandom_range(1)));
					if (pat_len != 0 && (full || $urandom_range(9) < 6)) begin
						sym = pat_sym[cp % pat_len];
						cp++;
					end else begin
						sym = ($urandom_range(19) == 0) ? SEP : alpha_sym(wide, a0, a1);
						cp  = 0;
					end
					send_word(OP_TEXT, sym, (i == tl - 1) && (full || $urandom_range(7) != 0));
				end
			end
		end
		steady = 1'b0;

		// drain
		in_ch.valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d input words (%0d random phases), %0d result words checked",
			words_in, phase, results_seen);
		$display("run: longest match %0d, %0d flush runs ended, %0d mismatches",
			longest, flush_runs, errors);
		if (errors == 0)
			$display("tb_z_array_prefix_match: clean");
		else
			$display("tb_z_array_prefix_match: errors");
		$finish;
	end

endmodule
